>>> sv/packet_fifo_byte_queue_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the packet FIFO byte queue
// ---------------------------------------------------------------------------
`ifndef PACKET_FIFO_BYTE_QUEUE_ASSERT_SVH
`define PACKET_FIFO_BYTE_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Next-cycle implication, disabled while reset is asserted.
`define PFQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

>>> sv/pfq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfq_pkg
// Shared types, constants and helpers of the packet FIFO byte queue.
// ---------------------------------------------------------------------------
package pfq_pkg;

    localparam int SLOT_COUNT       = 8;
    localparam int MAX_PACKET_BYTES = 250;
    localparam int SLOT_STRIDE      = 256;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int OFF_W     = $clog2(SLOT_STRIDE);
    localparam int CNT_W     = $clog2(SLOT_COUNT + 1);
    localparam int ADDR_W    = SLOT_W + OFF_W;
    localparam int MEM_DEPTH = SLOT_COUNT * SLOT_STRIDE;
    localparam int HELD_W    = 4;

    // command codes
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        out_byte;
        logic              out_last;
        logic [7:0]        packet_length;
        logic [HELD_W-1:0] packets_held;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic do_push;     // apply a push transaction
        logic do_empty;    // answer a pop on an empty ring
        logic do_rd_issue; // launch byte store read for a pop
        logic do_pop;      // finish a pop with the read data
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // result register can take a result this cycle
        logic count_zero;  // no complete packet held
    } t_dp_status;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage
`default_nettype wire

>>> sv/pfq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfq_in_if / pfq_out_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface pfq_in_if;
    import pfq_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pfq_out_if;
    import pfq_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/pfq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfq_ctrl
// Sequencer: accepts transactions and steps the datapath through them.
// ---------------------------------------------------------------------------
module pfq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_command,
    input  pfq_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output pfq_pkg::t_dp_cmd    o_cmd
);
    import pfq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    if (i_in_command == CMD_PUSH) begin
                        o_cmd.do_push = 1'b1;
                    end else if (i_status.count_zero) begin
                        o_cmd.do_empty = 1'b1;
                    end else begin
                        o_cmd.do_rd_issue = 1'b1;
                        n_state           = S_POP;
                    end
                end
            end
            S_POP: begin
                // read data is back; result register is free by construction
                o_cmd.do_pop = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> sv/pfq_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pfq_dpath
// Ring pointers, packet count, byte store, length table and result register.
// ---------------------------------------------------------------------------
module pfq_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pfq_pkg::t_in_item   i_item,
    input  pfq_pkg::t_dp_cmd    i_cmd,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output pfq_pkg::t_out_item  o_out_item,
    output pfq_pkg::t_dp_status o_status
);
    import pfq_pkg::*;
    `include "packet_fifo_byte_queue_assert.svh"

    logic [SLOT_W-1:0] r_read_slot,    n_read_slot;
    logic [SLOT_W-1:0] r_write_slot,   n_write_slot;
    logic [CNT_W-1:0]  r_packet_count, n_packet_count;
    logic [OFF_W-1:0]  r_write_offset, n_write_offset;
    logic [OFF_W-1:0]  r_read_offset,  n_read_offset;
    logic              r_refusing,     n_refusing;
    logic              r_out_valid;
    t_out_item         r_out_item,     n_out_item;

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_slot_len [SLOT_COUNT];
    logic [7:0] r_rd_data;

    logic              w_full_start;
    logic              w_below_max;
    logic [OFF_W-1:0]  w_woff_inc;
    logic              w_mem_we;
    logic              w_len_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_cur_len;
    logic [OFF_W-1:0]  w_roff_inc;
    logic              w_rd_last;
    logic              w_load;

    assign w_full_start = (r_write_offset == '0) && (r_packet_count >= CNT_W'(SLOT_COUNT));
    assign w_below_max  = r_write_offset < OFF_W'(MAX_PACKET_BYTES);
    assign w_woff_inc   = w_below_max ? r_write_offset + 1'b1 : r_write_offset;
    assign w_mem_we     = i_cmd.do_push && !r_refusing && !w_full_start && w_below_max;
    assign w_len_we     = i_cmd.do_push && !r_refusing && !w_full_start && i_item.last_byte;
    assign w_waddr      = {r_write_slot, r_write_offset};
    assign w_raddr      = {r_read_slot, r_read_offset};
    assign w_cur_len    = r_slot_len[r_read_slot];
    assign w_roff_inc   = r_read_offset + 1'b1;
    assign w_rd_last    = w_roff_inc >= w_cur_len;
    assign w_load       = i_cmd.do_push || i_cmd.do_empty || i_cmd.do_pop;

    // byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_waddr] <= i_item.data_byte;
        end
        if (i_cmd.do_rd_issue) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_len_we) begin
            r_slot_len[r_write_slot] <= w_woff_inc;
        end
    end

    always_comb begin
        n_read_slot    = r_read_slot;
        n_write_slot   = r_write_slot;
        n_packet_count = r_packet_count;
        n_write_offset = r_write_offset;
        n_read_offset  = r_read_offset;
        n_refusing     = r_refusing;
        n_out_item     = '0;

        if (i_cmd.do_push) begin
            if (r_refusing) begin
                n_out_item.status = ST_FULL;
                if (i_item.last_byte) begin
                    n_refusing = 1'b0;
                end
            end else if (w_full_start) begin
                n_out_item.status = ST_FULL;
                if (!i_item.last_byte) begin
                    n_refusing = 1'b1;
                end
            end else if (i_item.last_byte) begin
                n_write_slot   = next_slot(r_write_slot);
                n_packet_count = r_packet_count + 1'b1;
                n_write_offset = '0;
            end else begin
                n_write_offset = w_woff_inc;
            end
        end else if (i_cmd.do_empty) begin
            n_out_item.status = ST_EMPTY;
        end else if (i_cmd.do_pop) begin
            n_out_item.out_byte      = r_rd_data;
            n_out_item.packet_length = w_cur_len;
            n_out_item.out_last      = w_rd_last;
            if (w_rd_last) begin
                n_read_offset  = '0;
                n_read_slot    = next_slot(r_read_slot);
                n_packet_count = r_packet_count - 1'b1;
            end else begin
                n_read_offset = w_roff_inc;
            end
        end
        n_out_item.packets_held = HELD_W'(n_packet_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_slot    <= '0;
            r_write_slot   <= '0;
            r_packet_count <= '0;
            r_write_offset <= '0;
            r_read_offset  <= '0;
            r_refusing     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_read_slot    <= n_read_slot;
            r_write_slot   <= n_write_slot;
            r_packet_count <= n_packet_count;
            r_write_offset <= n_write_offset;
            r_read_offset  <= n_read_offset;
            r_refusing     <= n_refusing;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_item          = r_out_item;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.count_zero = (r_packet_count == '0);

    `PFQ_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_packet_count <= CNT_W'(SLOT_COUNT))
    `PFQ_ASSERT_NOW(a_woff_range, i_clk, i_rst_n, 1'b1, r_write_offset <= OFF_W'(MAX_PACKET_BYTES))
    `PFQ_ASSERT_NOW(a_refuse_at_start, i_clk, i_rst_n, r_refusing, r_write_offset == '0)
    `PFQ_ASSERT_NOW(a_pop_has_packet, i_clk, i_rst_n, i_cmd.do_pop, r_packet_count != '0)
    `PFQ_ASSERT_NOW(a_load_when_free, i_clk, i_rst_n, w_load, o_status.out_free)
    `PFQ_ASSERT_NEXT(a_issue_then_pop, i_clk, i_rst_n, i_cmd.do_rd_issue, i_cmd.do_pop)

endmodule
`default_nettype wire

>>> sv/packet_fifo_byte_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// packet_fifo_byte_queue
// Ring of fixed packet slots with a stored length per slot; byte-serial
// push and pop with packet refusal on a full ring and length clamping.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake      Payload
//  i_in     in   valid / ready  command, data_byte, last_byte
//  o_out    out  valid / ready  status, out_byte, out_last, packet_length,
//                               packets_held
//
//  Pushes and pops on an empty ring load the result register directly;
//  a pop that returns a byte first waits in S_POP for the registered byte
//  store read. One transaction is worked on at a time; a new one is taken
//  once its result can enter the result register, also in the cycle that
//  register is read out. A stalled o_out holds back i_in.
//  Synchronous active-low reset clears pointers, count and offsets; the
//  byte store and length table are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module packet_fifo_byte_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfq_in_if.sink     i_in,
    pfq_out_if.source  o_out
);
    import pfq_pkg::*;

    t_dp_cmd    w_cmd;     // sequencer commands to the datapath
    t_dp_status w_status;  // datapath flags back to the sequencer

    // Sequencer: decodes the accepted transaction and, for a pop with data,
    // waits in S_POP for the byte store read.
    pfq_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_command (i_in.data.command),
        .i_status     (w_status),
        .o_in_ready   (i_in.ready),
        .o_cmd        (w_cmd)
    );

    // Datapath: slot pointers, offsets, packet count, refusal flag,
    // 2048-byte store, per-slot length table and the result register.
    pfq_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_cmd       (w_cmd),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_item  (o_out.data),
        .o_status    (w_status)
    );

endmodule
`default_nettype wire

>>> tb/packet_fifo_byte_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_fifo_byte_queue_tb
// Self-checking regression for the packet FIFO byte queue. A table of
// directed transactions covers the corner cases. Random packet traffic
// follows, with random stalls on both channels. Every result is compared
// field by field with the directed table or a cycle-free model of the slot ring.
// ---------------------------------------------------------------------------
module packet_fifo_byte_queue_tb;
    import pfq_pkg::*;

    localparam int TOTAL_ITEMS = 1900;
    localparam int HOLD_CYCLES = 300;

    // one row of the directed table; want is only used when typed is set
    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    // Directed walk, starting from reset:
    //   pop on an empty ring, 1-byte packet with all data bits set,
    //   3-byte packet read back, empty again, eight 1-byte packets that
    //   wrap the slot index and fill the ring, a refused multi-byte packet,
    //   a refused packet whose first byte is also its last byte, then one
    //   pop to free a slot, one push to take it and a final pop.
    localparam int DIR_ROWS = 25;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b1, '{ST_EMPTY, 8'h00, 1'b0, 8'd0, 4'd0}},
        '{'{CMD_PUSH, 8'hFF, 1'b1}, 1'b1, '{ST_OK,    8'h00, 1'b0, 8'd0, 4'd1}},
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b1, '{ST_OK,    8'hFF, 1'b1, 8'd1, 4'd0}},
        '{'{CMD_PUSH, 8'h00, 1'b0}, 1'b1, '{ST_OK,    8'h00, 1'b0, 8'd0, 4'd0}},
        '{'{CMD_PUSH, 8'hA5, 1'b0}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h5A, 1'b1}, 1'b1, '{ST_OK,    8'h00, 1'b0, 8'd0, 4'd1}},
        '{'{CMD_POP,  8'hFF, 1'b1}, 1'b1, '{ST_OK,    8'h00, 1'b0, 8'd3, 4'd1}},
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_POP,  8'hFF, 1'b1}, 1'b1, '{ST_EMPTY, 8'h00, 1'b0, 8'd0, 4'd0}},
        '{'{CMD_PUSH, 8'h01, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h02, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h04, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h08, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h10, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h20, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h40, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h80, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h77, 1'b0}, 1'b1, '{ST_FULL,  8'h00, 1'b0, 8'd0, 4'd8}},
        '{'{CMD_PUSH, 8'h88, 1'b0}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h99, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h11, 1'b1}, 1'b1, '{ST_FULL,  8'h00, 1'b0, 8'd0, 4'd8}},
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b0, '0},
        '{'{CMD_PUSH, 8'h22, 1'b1}, 1'b0, '0},
        '{'{CMD_POP,  8'h00, 1'b0}, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    pfq_in_if  in_if ();
    pfq_out_if out_if ();

    packet_fifo_byte_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // ring model state, mirrors the block after every accepted transaction
    int         rd_slot;
    int         wr_slot;
    int         held;
    int         wr_off;
    int         rd_off;
    bit         refusing;
    int         slot_len  [SLOT_COUNT];
    logic [7:0] slot_data [SLOT_COUNT][SLOT_STRIDE];

    t_out_item  pending_results [$];
    int         items_sent;
    int         results_seen;
    int         error_count;
    bit         steady_phase;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("packet_fifo_byte_queue regression: fail");
        $finish;
    end

    // stretches where neither side idles
    initial begin
        steady_phase = 1'b0;
        forever begin
            repeat ($urandom_range(150, 400)) @(posedge i_clk);
            steady_phase <= ~steady_phase;
        end
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Next result of the ring for one transaction; updates the model state.
    function automatic t_out_item predict_result(input t_in_item stim);
        t_out_item res;
        res = '0;
        res.status = ST_OK;
        if (stim.command == CMD_PUSH) begin
            if (refusing) begin
                // rest of a refused packet is dropped up to its last byte
                res.status = ST_FULL;
                if (stim.last_byte)
                    refusing = 1'b0;
            end else if (wr_off == 0 && held >= SLOT_COUNT) begin
                // first byte meets a full ring: refuse the whole packet
                res.status = ST_FULL;
                if (!stim.last_byte)
                    refusing = 1'b1;
            end else begin
                // bytes past the maximum packet length are dropped silently
                if (wr_off < MAX_PACKET_BYTES) begin
                    slot_data[wr_slot][wr_off] = stim.data_byte;
                    wr_off++;
                end
                if (stim.last_byte) begin
                    slot_len[wr_slot] = wr_off;
                    wr_slot = (wr_slot == SLOT_COUNT - 1) ? 0 : wr_slot + 1;
                    held++;
                    wr_off = 0;
                end
            end
        end else if (held == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.out_byte      = slot_data[rd_slot][rd_off];
            res.packet_length = 8'(slot_len[rd_slot]);
            rd_off++;
            if (rd_off >= slot_len[rd_slot]) begin
                res.out_last = 1'b1;
                rd_off  = 0;
                rd_slot = (rd_slot == SLOT_COUNT - 1) ? 0 : rd_slot + 1;
                held--;
            end
        end
        res.packets_held = HELD_W'(held);
        return res;
    endfunction

    // Offer one transaction, wait for acceptance, record its expected result.
    // valid stays high when the next transaction follows without a gap.
    task automatic send_item(input t_in_item stim, input bit typed, input t_out_item want);
        t_out_item predicted;
        int        gap;
        in_if.valid <= 1'b1;
        in_if.data  <= stim;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = predict_result(stim);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
        gap = steady_phase ? 0 : pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // pop with junk in the ignored fields
    task automatic send_pop();
        t_in_item stim;
        stim.command   = CMD_POP;
        stim.data_byte = 8'($urandom);
        stim.last_byte = 1'($urandom);
        send_item(stim, 1'b0, '0);
    endtask

    // one well-formed packet, occasionally interleaved with a pop
    task automatic push_packet(input int len);
        t_in_item stim;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_pop();
            stim.command   = CMD_PUSH;
            stim.data_byte = 8'($urandom);
            stim.last_byte = (k == len - 1);
            send_item(stim, 1'b0, '0);
        end
    endtask

    // sender pause until every outstanding result has come back
    task automatic wait_all_results();
        if (pending_results.size() != 0) begin
            in_if.valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge i_clk);
        end
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stalls, two long hold-offs that back the block up
    // into its input, and the field-by-field check.
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int        stall;
        t_out_item got;
        t_out_item want;
        stall = 0;
        out_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1)
            @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got = out_if.data;
                if (pending_results.size() == 0) begin
                    $error("result with no transaction pending: status %0d byte %02h",
                           got.status, got.out_byte);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, actual %02h",
                               want.out_byte, got.out_byte);
                        error_count++;
                    end
                    if (got.out_last !== want.out_last) begin
                        $error("out_last: expected %0d, actual %0d",
                               want.out_last, got.out_last);
                        error_count++;
                    end
                    if (got.packet_length !== want.packet_length) begin
                        $error("packet_length: expected %0d, actual %0d",
                               want.packet_length, got.packet_length);
                        error_count++;
                    end
                    if (got.packets_held !== want.packets_held) begin
                        $error("packets_held: expected %0d, actual %0d",
                               want.packets_held, got.packets_held);
                        error_count++;
                    end
                end
                results_seen++;
                // long hold-off while the sender keeps offering
                if (results_seen == 400 || results_seen == 1300)
                    stall = HOLD_CYCLES;
            end
            if (stall > 0)
                stall--;
            else if (!steady_phase && $urandom_range(0, 99) < 20)
                stall = pick_gap();
            out_if.ready <= (stall == 0);
        end
    end

    // -----------------------------------------------------------------------
    // Command side: reset, directed table, random packet traffic, drain.
    // -----------------------------------------------------------------------
    initial begin : stimulus
        bit       filling;
        int       flip_at;
        int       big_stage;
        int       roll;
        int       len;
        int       guard;
        t_in_item stim;

        i_rst_n     <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        rd_slot      = 0;
        wr_slot      = 0;
        held         = 0;
        wr_off       = 0;
        rd_off       = 0;
        refusing     = 1'b0;
        items_sent   = 0;
        results_seen = 0;
        error_count  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases; typed rows carry their expected result
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(DIRECTED[r].stim, DIRECTED[r].typed, DIRECTED[r].want);
        wait_all_results();

        // Random traffic. The push/pop mix swings between filling and
        // draining so the ring runs both full (refusals) and empty.
        filling   = 1'b1;
        flip_at   = items_sent + 150;
        big_stage = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= flip_at) begin
                filling = !filling;
                flip_at = items_sent + $urandom_range(80, 200);
            end
            // one packet of exactly the maximum length, later one that overflows
            // it and gets clamped; any open or refused packet is closed and
            // a slot is freed first so neither is refused
            if ((big_stage == 0 && items_sent >= 400) ||
                (big_stage == 1 && items_sent >= 1100)) begin
                wait_all_results();
                while (held >= SLOT_COUNT || refusing || wr_off != 0) begin
                    if (refusing || wr_off != 0) begin
                        stim.command   = CMD_PUSH;
                        stim.data_byte = 8'($urandom);
                        stim.last_byte = 1'b1;
                        send_item(stim, 1'b0, '0);
                    end else begin
                        send_pop();
                    end
                end
                push_packet(big_stage == 0 ? MAX_PACKET_BYTES : MAX_PACKET_BYTES + 3);
                big_stage++;
                continue;
            end
            roll = $urandom_range(0, 99);
            if (roll < (filling ? 55 : 25)) begin
                len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 5)
                                                  : $urandom_range(6, 30);
                push_packet(len);
            end else if (roll < 85) begin
                repeat ($urandom_range(1, 12)) send_pop();
            end else begin
                // noise: any field combination, also stray last flags
                stim = t_in_item'(10'($urandom_range(0, 1023)));
                send_item(stim, 1'b0, '0);
            end
        end

        in_if.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("packet_fifo_byte_queue regression: pass");
        else
            $display("packet_fifo_byte_queue regression: fail");
        $finish;
    end

endmodule
